/* src/crcdf_pkg.sv */
`timescale 1ns / 1ps

package crcdf_pkg;

  // Widths fixed by the interface.
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 16;
  localparam int INDEX_W = 6;

  // Header register reset value and CRC-8 constants.
  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
  localparam logic [BYTE_W-1:0] CRC_POLY     = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_INIT     = 8'h00;

  // One finished packet, handed from the front to the back.
  typedef struct packed {
    logic               bad;
    logic               bank;
    logic [COUNT_W-1:0] good_count;
    logic [COUNT_W-1:0] bad_count;
  } cmd_t;

  // The back hands a buffer bank back to the front once it has read it out.
  typedef struct packed {
    logic done;
    logic bank;
  } release_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD,
    BK_ERR
  } back_state_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* src/crcdf_fifo.sv */
`timescale 1ns / 1ps

module crcdf_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  crcdf_pkg::cmd_t     push_cmd,
  output logic                full,
  input  logic                pop,
  output crcdf_pkg::cmd_t     pop_cmd,
  output logic                empty
);

  crcdf_pkg::cmd_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_cmd = entries[rd_ptr];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/crcdf_front.sv */
`timescale 1ns / 1ps

module crcdf_front #(
  parameter int PACKET_BYTES = 14,
  parameter int IDX_W        = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rx_valid,
  input  logic [crcdf_pkg::BYTE_W-1:0]        rx_byte,
  output logic                                rx_stall,
  input  logic                                cfg_we,
  input  logic [crcdf_pkg::BYTE_W-1:0]        cfg_wdata,
  output logic                                push,
  output crcdf_pkg::cmd_t                     push_cmd,
  input  logic                                q_full,
  input  crcdf_pkg::release_t                 rel,
  output logic                                wr_en,
  output logic                                wr_bank,
  output logic [IDX_W-1:0]                    wr_idx,
  output logic [crcdf_pkg::BYTE_W-1:0]        wr_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

  logic [crcdf_pkg::BYTE_W-1:0]  header_value;
  logic                          collecting;
  logic [IDX_W-1:0]              fill_count;
  logic [crcdf_pkg::BYTE_W-1:0]  running_crc;
  logic [crcdf_pkg::COUNT_W-1:0] accepted_total;
  logic [crcdf_pkg::COUNT_W-1:0] rejected_total;
  logic                          bank;
  logic [1:0]                    busy;

  logic                          accept;
  logic                          hdr_match;
  logic                          at_check;
  logic                          crc_ok;
  logic [crcdf_pkg::COUNT_W-1:0] accepted_next;
  logic [crcdf_pkg::COUNT_W-1:0] rejected_next;
  logic [crcdf_pkg::BYTE_W-1:0]  crc_seed;

  // Hold input while the queue is full or the fill bank still awaits readout.
  assign rx_stall = q_full || busy[bank];
  assign accept   = rx_valid && !rx_stall;

  assign hdr_match = (rx_byte == header_value);
  assign at_check  = collecting && (fill_count == LAST_IDX);
  assign crc_ok    = (rx_byte == running_crc);

  // Counter values after this transfer.
  assign accepted_next = accepted_total + crcdf_pkg::COUNT_W'(push && crc_ok);
  assign rejected_next = rejected_total + crcdf_pkg::COUNT_W'(push && !crc_ok);

  // A finished packet is queued on its check byte.
  assign push                = accept && at_check;
  assign push_cmd.bad        = !crc_ok;
  assign push_cmd.bank       = bank;
  assign push_cmd.good_count = accepted_next;
  assign push_cmd.bad_count  = rejected_next;

  // Buffer write port: header, data bytes and a matching check byte.
  assign wr_en   = accept && (collecting ? (!at_check || crc_ok) : hdr_match);
  assign wr_bank = bank;
  assign wr_idx  = collecting ? fill_count : '0;
  assign wr_data = rx_byte;

  assign crc_seed = collecting ? running_crc : crcdf_pkg::CRC_INIT;

  // Header register.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= crcdf_pkg::HEADER_RESET;
    end else if (cfg_we) begin
      header_value <= cfg_wdata;
    end
  end

  // Hunt and collect.
  always_ff @(posedge clk) begin
    if (rst) begin
      collecting     <= 1'b0;
      fill_count     <= '0;
      running_crc    <= crcdf_pkg::CRC_INIT;
      accepted_total <= '0;
      rejected_total <= '0;
      bank           <= 1'b0;
    end else if (accept) begin
      if (at_check) begin
        collecting     <= 1'b0;
        fill_count     <= '0;
        running_crc    <= crcdf_pkg::CRC_INIT;
        accepted_total <= accepted_next;
        rejected_total <= rejected_next;
        if (crc_ok) begin
          bank <= ~bank;
        end
      end else if (collecting || hdr_match) begin
        collecting  <= 1'b1;
        fill_count  <= (collecting ? fill_count : '0) + IDX_W'(1);
        running_crc <= crcdf_pkg::crc8_feed(crc_seed, rx_byte);
      end
    end
  end

  // A bank is busy from its verified check byte until the back has read it.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 2'b00;
    end else begin
      if (rel.done) begin
        busy[rel.bank] <= 1'b0;
      end
      if (push && crc_ok) begin
        busy[bank] <= 1'b1;
      end
    end
  end

endmodule

/* src/crcdf_back.sv */
`timescale 1ns / 1ps

module crcdf_back #(
  parameter int PACKET_BYTES = 14,
  parameter int IDX_W        = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic                                 wr_bank,
  input  logic [IDX_W-1:0]                     wr_idx,
  input  logic [crcdf_pkg::BYTE_W-1:0]         wr_data,
  input  logic                                 q_empty,
  input  crcdf_pkg::cmd_t                      q_cmd,
  output logic                                 pop,
  output crcdf_pkg::release_t                  rel,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic [crcdf_pkg::BYTE_W-1:0]         data_byte,
  output logic [crcdf_pkg::INDEX_W-1:0]        byte_index,
  output logic                                 last,
  output logic                                 status,
  output logic [crcdf_pkg::COUNT_W-1:0]        good_count,
  output logic [crcdf_pkg::COUNT_W-1:0]        bad_count
);

  localparam int               OUT_IDX_W = crcdf_pkg::INDEX_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PACKET_BYTES - 1);

  // Two packet buffers: the front fills one while the other is read out.
  logic [crcdf_pkg::BYTE_W-1:0] mem [2][PACKET_BYTES];
  logic [crcdf_pkg::BYTE_W-1:0] rd_data;

  crcdf_pkg::back_state_t state;
  crcdf_pkg::back_state_t state_next;
  crcdf_pkg::cmd_t        cur_cmd;
  logic [IDX_W-1:0]       idx;

  logic                          out_free;
  logic                          load;
  logic                          idx_inc;
  logic [crcdf_pkg::BYTE_W-1:0]  ld_data;
  logic [OUT_IDX_W-1:0]          ld_index;
  logic                          ld_last;
  logic                          ld_status;

  assign out_free = !res_valid || !res_stall;

  // Buffer write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_bank][wr_idx] <= wr_data;
    end
    rd_data <= mem[cur_cmd.bank][idx];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crcdf_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and result selection.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    idx_inc    = 1'b0;
    rel.done   = 1'b0;
    rel.bank   = cur_cmd.bank;
    ld_data    = rd_data;
    ld_index   = OUT_IDX_W'(idx);
    ld_last    = (idx == LAST_IDX);
    ld_status  = 1'b0;
    case (state)
      crcdf_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = q_cmd.bad ? crcdf_pkg::BK_ERR : crcdf_pkg::BK_READ;
        end
      end
      crcdf_pkg::BK_READ: begin
        state_next = crcdf_pkg::BK_LOAD;
      end
      crcdf_pkg::BK_LOAD: begin
        if (out_free) begin
          load = 1'b1;
          if (idx == LAST_IDX) begin
            rel.done   = 1'b1;
            state_next = crcdf_pkg::BK_IDLE;
          end else begin
            idx_inc    = 1'b1;
            state_next = crcdf_pkg::BK_READ;
          end
        end
      end
      crcdf_pkg::BK_ERR: begin
        ld_data   = '0;
        ld_index  = OUT_IDX_W'(PACKET_BYTES - 1);
        ld_last   = 1'b1;
        ld_status = 1'b1;
        if (out_free) begin
          load       = 1'b1;
          state_next = crcdf_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = crcdf_pkg::BK_IDLE;
      end
    endcase
  end

  // Current packet and read position.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_cmd <= q_cmd;
      idx     <= '0;
    end else if (idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_byte  <= ld_data;
      byte_index <= ld_index;
      last       <= ld_last;
      status     <= ld_status;
      good_count <= cur_cmd.good_count;
      bad_count  <= cur_cmd.bad_count;
    end
  end

endmodule

/* src/crc8_packet_deframer.sv */
`timescale 1ns / 1ps
// Input: one byte per cycle while hunting or collecting; input stalls while the
// command queue is full or the next fill buffer still holds a packet being read out.
// Output: the back pops a finished packet, then per byte reads the buffer (BK_READ) and
// loads the output register (BK_LOAD) once it is free; an error packet loads one error
// result (BK_ERR). Reset (rst, synchronous, active high) clears counters, queue and
// control state, sets header_value to 0xAA; buffers keep data.

module crc8_packet_deframer #(
  parameter int PACKET_BYTES = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  data_byte,
  output logic [5:0]  byte_index,
  output logic        last,
  output logic        status,
  output logic [15:0] good_count,
  output logic [15:0] bad_count
);

  localparam int IDX_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

  logic                         push;
  crcdf_pkg::cmd_t              push_cmd;
  logic                         q_full;
  logic                         q_empty;
  logic                         pop;
  crcdf_pkg::cmd_t              q_cmd;
  crcdf_pkg::release_t          rel;
  logic                         wr_en;
  logic                         wr_bank;
  logic [IDX_W-1:0]             wr_idx;
  logic [crcdf_pkg::BYTE_W-1:0] wr_data;

  // Front: header hunt, CRC and buffer fill.
  crcdf_front #(
    .PACKET_BYTES (PACKET_BYTES),
    .IDX_W        (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_byte   (rx_byte),
    .rx_stall  (rx_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full),
    .rel       (rel),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data)
  );

  // Queue of finished packets.
  crcdf_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty)
  );

  // Back: buffer readout and result emission.
  crcdf_back #(
    .PACKET_BYTES (PACKET_BYTES),
    .IDX_W        (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_bank    (wr_bank),
    .wr_idx     (wr_idx),
    .wr_data    (wr_data),
    .q_empty    (q_empty),
    .q_cmd      (q_cmd),
    .pop        (pop),
    .rel        (rel),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .data_byte  (data_byte),
    .byte_index (byte_index),
    .last       (last),
    .status     (status),
    .good_count (good_count),
    .bad_count  (bad_count)
  );

endmodule

/* src/crcdf_checker.sv */
`timescale 1ns / 1ps

module crcdf_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_valid,
  input logic        rx_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic [7:0]  data_byte,
  input logic [5:0]  byte_index,
  input logic        last,
  input logic        status,
  input logic [15:0] good_count,
  input logic [15:0] bad_count
);

  // A stalled result holds until it is transferred.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(data_byte) && $stable(byte_index)
      && $stable(last) && $stable(status))
    else $error("stalled result changed");

  // No result is presented right after a reset cycle.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // An error result is a single zero byte closing the packet.
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && status |-> last && data_byte == 8'd0 && byte_index != 6'd0)
    else $error("malformed error result");

  // The input stall is always defined while a byte is offered.
  a_stall_known: assert property (@(posedge clk) disable iff (rst)
    rx_valid |-> !$isunknown(rx_stall))
    else $error("input stall unknown");

  // Every result carries defined packet counters.
  a_counts_known: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !$isunknown({good_count, bad_count}))
    else $error("result counters unknown");

endmodule

bind crc8_packet_deframer crcdf_checker u_crcdf_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_valid   (rx_valid),
  .rx_stall   (rx_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .data_byte  (data_byte),
  .byte_index (byte_index),
  .last       (last),
  .status     (status),
  .good_count (good_count),
  .bad_count  (bad_count)
);
